### rtl/core/ohlc_period_bar_window_top_macros.svh
// Assertion helpers for the bar window block.
`ifndef OHLC_PERIOD_BAR_WINDOW_TOP_MACROS_SVH
`define OHLC_PERIOD_BAR_WINDOW_TOP_MACROS_SVH

// Checks that a condition implies a consequence in the same cycle.
`define OHLC_ASSERT_IMP(label, clk, rstn, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (cons)) \
        else $error("assertion failed");

// Checks that a condition implies a consequence in the following cycle.
`define OHLC_ASSERT_NEXT(label, clk, rstn, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/core/ohlc_pkg.sv
package ohlc_pkg;
    localparam int WindowDepth = 16;
    localparam int SlotW = $clog2(WindowDepth);
    localparam int HeldW = $clog2(WindowDepth + 1);
    localparam int MaxGapFill = 31;
    localparam int GapW = 5;
    localparam int BarW = 192;

    localparam logic [2:0] EV_ADD = 3'd0;
    localparam logic [2:0] EV_ADD_EVICT = 3'd1;
    localparam logic [2:0] EV_EVICTED = 3'd2;
    localparam logic [2:0] EV_BEFORE = 3'd3;
    localparam logic [2:0] EV_AFTER = 3'd4;

    localparam logic CFG_PERIOD = 1'b0;
    localparam logic CFG_WINDOW = 1'b1;

    typedef struct packed {
        logic [31:0] t;
        logic [31:0] o;
        logic [31:0] h;
        logic [31:0] l;
        logic [31:0] c;
        logic [31:0] v;
    } bar_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIV, ST_RDBACK, ST_DECIDE, ST_GAPDIV, ST_FILL_START,
        ST_INS_RD, ST_INS_EVICT, ST_INS_WR, ST_MERGE, ST_OUT_WAIT
    } state_t;

    // Request from the sequencer to the divider.
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [21:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] quot;
    } div_rsp_t;
endpackage

### rtl/core/ohlc_ram.sv
module ohlc_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/core/ohlc_div.sv
module ohlc_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  ohlc_pkg::div_req_t req,
    output ohlc_pkg::div_rsp_t rsp
);
    // Restoring division, one quotient bit per cycle.
    logic [31:0] quot_reg, quot_next;
    logic [21:0] rem_reg, rem_next;
    logic [21:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [22:0] trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        quot_reg <= quot_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    always_comb begin
        quot_next = quot_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {rem_reg, quot_reg[31]} - {1'b0, dvs_reg};
        if (req.start) begin
            quot_next = req.dividend;
            rem_next = '0;
            dvs_next = req.divisor;
            cnt_next = 6'd32;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[22]) begin
                rem_next = trial[21:0];
                quot_next = {quot_reg[30:0], 1'b1};
            end else begin
                rem_next = {rem_reg[20:0], quot_reg[31]};
                quot_next = {quot_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
endmodule

### rtl/core/ohlc_period_bar_window_top.sv
// Channel  Ports                                Direction
// tick     s_valid/s_ready, s_tick_*            in
// event    m_valid/m_ready, m_event_kind, m_bar_*, m_last_of_run  out
// config   cfg_we, cfg_index, cfg_wdata         in
//
// A tick is accepted, then passes the period rounding (a 32-step serial
// divider) and a read of the newest bar; a gap adds a division for the gap
// count. An eviction adds its own event before the added bar, and a merge
// emits a before/after pair. An empty window skips the newest-bar read.
// aresetn is synchronous, active low; it empties the window and restores the
// registers to a 60 s period and a window of 16.
// Each event waits in the output register until taken; work halts meanwhile.
`include "ohlc_period_bar_window_top_macros.svh"

module ohlc_period_bar_window_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [21:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_tick_time,
    input  logic [31:0] s_tick_open,
    input  logic [31:0] s_tick_high,
    input  logic [31:0] s_tick_low,
    input  logic [31:0] s_tick_close,
    input  logic [31:0] s_tick_volume,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_kind,
    output logic [31:0] m_bar_time,
    output logic [31:0] m_bar_open,
    output logic [31:0] m_bar_high,
    output logic [31:0] m_bar_low,
    output logic [31:0] m_bar_close,
    output logic [31:0] m_bar_volume,
    output logic        m_last_of_run
);
    localparam int SW = ohlc_pkg::SlotW;
    localparam int HW = ohlc_pkg::HeldW;
    localparam int GapW_L = ohlc_pkg::GapW;

    logic [21:0] period_reg;
    logic [4:0]  window_reg;
    logic [21:0] per_eff;
    logic [HW-1:0] win_eff;

    ohlc_pkg::state_t state_reg, state_next, ret_reg, ret_next;
    ohlc_pkg::bar_t tick_reg, tick_next;     // tick bar, time rounded
    ohlc_pkg::bar_t back_reg, back_next;     // newest bar
    ohlc_pkg::bar_t ins_reg, ins_next;       // bar being inserted
    logic [31:0] adj_reg, adj_next;
    logic [SW-1:0] oldest_reg, oldest_next;
    logic [HW-1:0] held_reg, held_next;
    logic [GapW_L-1:0] fills_reg, fills_next;
    logic [31:0] ftime_reg, ftime_next;
    logic        is_tick_reg, is_tick_next;

    logic        ov_reg, ov_next;
    logic [2:0]  okind_reg, okind_next;
    ohlc_pkg::bar_t obar_reg, obar_next;
    logic        olast_reg, olast_next;

    ohlc_pkg::div_req_t dreq;
    ohlc_pkg::div_rsp_t drsp;

    logic            mwe;
    logic [SW-1:0]   mwaddr, mraddr;
    ohlc_pkg::bar_t  mwdata, mrdata;
    logic [ohlc_pkg::BarW-1:0] mrraw;

    ohlc_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    ohlc_ram #(.Width(ohlc_pkg::BarW), .Depth(ohlc_pkg::WindowDepth)) u_ram (
        .aclk(aclk), .we(mwe), .waddr(mwaddr), .wdata(mwdata),
        .raddr(mraddr), .rdata(mrraw)
    );
    assign mrdata = mrraw;

    assign per_eff = (period_reg == '0) ? 22'd1 : period_reg;
    always_comb begin
        if (window_reg == '0) begin
            win_eff = HW'(1);
        end else if ({1'b0, window_reg} > 6'(ohlc_pkg::WindowDepth)) begin
            win_eff = HW'(ohlc_pkg::WindowDepth);
        end else begin
            win_eff = HW'(window_reg);
        end
    end

    logic [63:0] prod;
    logic [SW-1:0] newest_slot, tail_slot;
    logic [32:0] vsum;
    assign prod = 64'(drsp.quot) * 64'(per_eff);
    assign newest_slot = SW'(oldest_reg + SW'(held_reg) - SW'(1));
    assign tail_slot = SW'(oldest_reg + SW'(held_reg));
    assign vsum = {1'b0, back_reg.v} + {1'b0, tick_reg.v};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= 22'd60;
            window_reg <= 5'd16;
            state_reg <= ohlc_pkg::ST_IDLE;
            ret_reg <= ohlc_pkg::ST_IDLE;
            oldest_reg <= '0;
            held_reg <= '0;
            ov_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == ohlc_pkg::CFG_PERIOD) begin
                    period_reg <= cfg_wdata;
                end else begin
                    window_reg <= cfg_wdata[4:0];
                end
            end
            state_reg <= state_next;
            ret_reg <= ret_next;
            oldest_reg <= oldest_next;
            held_reg <= held_next;
            ov_reg <= ov_next;
        end
        tick_reg <= tick_next;
        back_reg <= back_next;
        ins_reg <= ins_next;
        adj_reg <= adj_next;
        fills_reg <= fills_next;
        ftime_reg <= ftime_next;
        is_tick_reg <= is_tick_next;
        okind_reg <= okind_next;
        obar_reg <= obar_next;
        olast_reg <= olast_next;
    end

    always_comb begin
        state_next = state_reg;
        ret_next = ret_reg;
        tick_next = tick_reg;
        back_next = back_reg;
        ins_next = ins_reg;
        adj_next = adj_reg;
        oldest_next = oldest_reg;
        held_next = held_reg;
        fills_next = fills_reg;
        ftime_next = ftime_reg;
        is_tick_next = is_tick_reg;
        ov_next = ov_reg;
        okind_next = okind_reg;
        obar_next = obar_reg;
        olast_next = olast_reg;
        dreq = '0;
        mwe = 1'b0;
        mwaddr = tail_slot;
        mwdata = ins_reg;
        mraddr = newest_slot;
        s_ready = 1'b0;
        unique case (state_reg)
            ohlc_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    tick_next = '{t: s_tick_time, o: s_tick_open, h: s_tick_high,
                                  l: s_tick_low, c: s_tick_close, v: s_tick_volume};
                    dreq.start = 1'b1;
                    dreq.dividend = s_tick_time;
                    dreq.divisor = per_eff;
                    state_next = ohlc_pkg::ST_DIV;
                end
            end
            ohlc_pkg::ST_DIV: begin
                if (drsp.done) begin
                    adj_next = prod[31:0];
                    tick_next.t = prod[31:0];
                    if (held_reg == '0) begin
                        ins_next = tick_next;
                        is_tick_next = 1'b1;
                        state_next = ohlc_pkg::ST_INS_RD;
                    end else begin
                        state_next = ohlc_pkg::ST_RDBACK;
                    end
                end
            end
            ohlc_pkg::ST_RDBACK: begin
                // Memory read issued at newest slot; data arrives next cycle.
                state_next = ohlc_pkg::ST_DECIDE;
            end
            ohlc_pkg::ST_DECIDE: begin
                back_next = mrdata;
                if (mrdata.t < adj_reg) begin
                    dreq.start = 1'b1;
                    dreq.dividend = adj_reg - mrdata.t - 32'd1;
                    dreq.divisor = per_eff;
                    state_next = ohlc_pkg::ST_GAPDIV;
                end else begin
                    okind_next = ohlc_pkg::EV_BEFORE;
                    obar_next = mrdata;
                    olast_next = 1'b0;
                    ov_next = 1'b1;
                    ret_next = ohlc_pkg::ST_MERGE;
                    state_next = ohlc_pkg::ST_OUT_WAIT;
                end
            end
            ohlc_pkg::ST_GAPDIV: begin
                if (drsp.done) begin
                    if (drsp.quot > 32'(ohlc_pkg::MaxGapFill)) begin
                        fills_next = GapW_L'(ohlc_pkg::MaxGapFill);
                    end else begin
                        fills_next = drsp.quot[GapW_L-1:0];
                    end
                    state_next = ohlc_pkg::ST_FILL_START;
                end
            end
            ohlc_pkg::ST_FILL_START: begin
                // First filler index is gaps - fills + 1.
                ftime_next = 32'(prod[31:0] - 32'(fills_reg) * 32'(per_eff))
                             + back_reg.t + 32'(per_eff);
                if (fills_reg != '0) begin
                    ins_next = '{t: ftime_next, o: back_reg.c, h: back_reg.c,
                                 l: back_reg.c, c: back_reg.c, v: 32'd0};
                    is_tick_next = 1'b0;
                end else begin
                    ins_next = tick_reg;
                    is_tick_next = 1'b1;
                end
                state_next = ohlc_pkg::ST_INS_RD;
            end
            ohlc_pkg::ST_INS_RD: begin
                mraddr = oldest_reg;
                if (held_reg >= win_eff) begin
                    state_next = ohlc_pkg::ST_INS_EVICT;
                end else begin
                    state_next = ohlc_pkg::ST_INS_WR;
                    okind_next = ohlc_pkg::EV_ADD;
                end
            end
            ohlc_pkg::ST_INS_EVICT: begin
                okind_next = ohlc_pkg::EV_EVICTED;
                obar_next = mrdata;
                olast_next = 1'b0;
                ov_next = 1'b1;
                oldest_next = SW'(oldest_reg + SW'(1));
                held_next = held_reg - HW'(1);
                ret_next = ohlc_pkg::ST_INS_WR;
                state_next = ohlc_pkg::ST_OUT_WAIT;
            end
            ohlc_pkg::ST_INS_WR: begin
                mwe = 1'b1;
                okind_next = (okind_reg == ohlc_pkg::EV_EVICTED) ?
                             ohlc_pkg::EV_ADD_EVICT : ohlc_pkg::EV_ADD;
                obar_next = ins_reg;
                olast_next = is_tick_reg;
                ov_next = 1'b1;
                held_next = held_reg + HW'(1);
                if (is_tick_reg) begin
                    ret_next = ohlc_pkg::ST_IDLE;
                end else begin
                    fills_next = fills_reg - GapW_L'(1);
                    ftime_next = ftime_reg + 32'(per_eff);
                    if (fills_reg == GapW_L'(1)) begin
                        ins_next = tick_reg;
                        is_tick_next = 1'b1;
                    end else begin
                        ins_next.t = ftime_reg + 32'(per_eff);
                    end
                    ret_next = ohlc_pkg::ST_INS_RD;
                end
                state_next = ohlc_pkg::ST_OUT_WAIT;
            end
            ohlc_pkg::ST_MERGE: begin
                mwe = 1'b1;
                mwaddr = newest_slot;
                mwdata = back_reg;
                if (tick_reg.h > back_reg.h) mwdata.h = tick_reg.h;
                if (tick_reg.l < back_reg.l) mwdata.l = tick_reg.l;
                mwdata.c = tick_reg.c;
                mwdata.v = vsum[32] ? 32'hFFFF_FFFF : vsum[31:0];
                okind_next = ohlc_pkg::EV_AFTER;
                obar_next = mwdata;
                olast_next = 1'b1;
                ov_next = 1'b1;
                ret_next = ohlc_pkg::ST_IDLE;
                state_next = ohlc_pkg::ST_OUT_WAIT;
            end
            ohlc_pkg::ST_OUT_WAIT: begin
                if (m_ready) begin
                    ov_next = 1'b0;
                    state_next = ret_reg;
                end
            end
            default: state_next = ohlc_pkg::ST_IDLE;
        endcase
    end

    assign m_valid = ov_reg;
    assign m_event_kind = okind_reg;
    assign m_bar_time = obar_reg.t;
    assign m_bar_open = obar_reg.o;
    assign m_bar_high = obar_reg.h;
    assign m_bar_low = obar_reg.l;
    assign m_bar_close = obar_reg.c;
    assign m_bar_volume = obar_reg.v;
    assign m_last_of_run = olast_reg;

    `OHLC_ASSERT_IMP(a_held_bound, aclk, aresetn, 1'b1,
        held_reg <= HW'(ohlc_pkg::WindowDepth))
    `OHLC_ASSERT_IMP(a_ready_no_out, aclk, aresetn, s_ready, !m_valid)
    `OHLC_ASSERT_NEXT(a_merge_last, aclk, aresetn,
        state_reg == ohlc_pkg::ST_MERGE, m_valid && m_last_of_run)
    `OHLC_ASSERT_IMP(a_div_idle, aclk, aresetn, dreq.start, !drsp.busy)
endmodule
